FILE: rtl/vm86_sensitive_insn_monitor_macros.svh
// ----------------------------------------------------------------------------
// vm86 sensitive instruction monitor - assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef VM86_SENSITIVE_INSN_MONITOR_MACROS_SVH
`define VM86_SENSITIVE_INSN_MONITOR_MACROS_SVH

// same-cycle implication, masked while in reset
`define VSIM_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vsim check failed");

// next-cycle implication, masked while in reset
`define VSIM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vsim check failed");

// behaviour on the cycle after reset
`define VSIM_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("vsim reset check failed");

`endif

FILE: rtl/vsim_pkg.sv
// ----------------------------------------------------------------------------
// vsim_pkg
// types, opcodes and decode helpers for the vm86 sensitive instruction monitor
// ----------------------------------------------------------------------------
package vsim_pkg;

   // number of code bytes examined for prefixes
   localparam int PREFIX_WINDOW = 4;
   localparam int CODE_BYTES    = 4;
   localparam int SCAN_LIMIT    = (PREFIX_WINDOW < CODE_BYTES) ? PREFIX_WINDOW : CODE_BYTES;

   // operation selector
   localparam logic OP_EMULATE     = 1'b0;
   localparam logic OP_TABLE_WRITE = 1'b1;

   // prefix and opcode bytes
   localparam logic [7:0] PFX_DATA32 = 8'h66;
   localparam logic [7:0] PFX_ADDR32 = 8'h67;
   localparam logic [7:0] OPC_INT    = 8'hCD;
   localparam logic [7:0] OPC_PUSHF  = 8'h9C;
   localparam logic [7:0] OPC_POPF   = 8'h9D;
   localparam logic [7:0] OPC_IRET   = 8'hCF;
   localparam logic [7:0] OPC_CLI    = 8'hFA;
   localparam logic [7:0] OPC_STI    = 8'hFB;

   // special interrupt vectors
   localparam logic [7:0] VEC_BREAK = 8'h03;
   localparam logic [7:0] VEC_EXIT  = 8'hFB;
   localparam logic [7:0] VEC_SLEEP = 8'hFC;

   // flag bits
   localparam logic [31:0] FLAG_IF    = 32'h0000_0200;
   localparam logic [31:0] FLAG_VM    = 32'h0002_0000;
   localparam logic [31:0] FLAGS_KEPT = 32'h0000_0DFF;
   localparam logic [31:0] WORD_MASK  = 32'h0000_FFFF;

   typedef enum logic [1:0] {
      OUT_EMULATED  = 2'd0,
      OUT_TERMINATE = 2'd1,
      OUT_SLEEP     = 2'd2,
      OUT_UNHANDLED = 2'd3
   } outcome_type;

   // request beat payload, first field in the lowest bits
   typedef struct packed {
      logic [6:0]  pad;
      logic [31:0] table_value;
      logic [7:0]  table_index;
      logic [31:0] stack_word2;
      logic [31:0] stack_word1;
      logic [31:0] stack_word0;
      logic [31:0] flags_in;
      logic [15:0] sp_in;
      logic [15:0] ip_in;
      logic [15:0] cs_in;
      logic [31:0] code_window;
      logic        in_vm86;
   } req_item_type;

   // response beat payload, first field in the lowest bits
   typedef struct packed {
      logic [3:0]  pad;
      logic [31:0] store2;
      logic [31:0] store1;
      logic [31:0] store0;
      logic        store_wide;
      logic [1:0]  store_count;
      logic        vif_out;
      logic [31:0] flags_out;
      logic [15:0] sp_out;
      logic [15:0] ip_out;
      logic [15:0] cs_out;
   } rsp_item_type;

   // result of the prefix scan
   typedef struct packed {
      logic       found;
      logic       data32;
      logic [2:0] pos;
      logic [7:0] opcode;
      logic       vec_ok;
      logic [7:0] vec;
   } decode_type;

   // skip operand and address size prefixes, locate opcode and vector byte
   function automatic decode_type scan_code(input logic [31:0] win);
      decode_type d;
      logic [7:0] b;
      d = '0;
      b = '0;
      for (int i = 0; i < CODE_BYTES; i++) begin
         if (!d.found && (i < SCAN_LIMIT)) begin
            b = win[8*i +: 8];
            if (b == PFX_DATA32) begin
               d.data32 = 1'b1;
            end
            if ((b != PFX_DATA32) && (b != PFX_ADDR32)) begin
               d.found  = 1'b1;
               d.opcode = b;
            end else begin
               d.pos = d.pos + 3'd1;
            end
         end
      end
      // vector byte follows the opcode, if it lies inside the window
      d.vec_ok = d.found && (d.pos < 3'd3);
      case (d.pos)
         3'd0:    d.vec = win[15:8];
         3'd1:    d.vec = win[23:16];
         3'd2:    d.vec = win[31:24];
         default: d.vec = 8'h00;
      endcase
      return d;
   endfunction

   // put the virtual interrupt flag into a flags image
   function automatic logic [31:0] with_vif(input logic [31:0] v, input logic vif);
      return vif ? (v | FLAG_IF) : (v & ~FLAG_IF);
   endfunction

endpackage

FILE: rtl/vm86_sensitive_insn_monitor.sv
// ----------------------------------------------------------------------------
// vm86_sensitive_insn_monitor
// emulates INT n, PUSHF, POPF, IRET, CLI and STI for a trapped vm86 task
// ----------------------------------------------------------------------------
// The block takes one beat per clock unless back-pressure stalls it, and
// returns exactly one response beat for each, in order. The accepting edge
// loads the input register, scans the prefixes and reads the 256-entry vector
// table through its registered read port. The response register is loaded
// from the decode and add logic as the beat advances, and holds the response
// until the response side takes it. Table-write beats (req_tuser high) update
// the vector table at acceptance, so an INT accepted on the very next cycle
// already sees the new entry. The virtual interrupt flag changes as each beat
// moves into the response register. Entries that were never written read as
// unknown data. Back-pressure on rsp_tready stalls both stages without losing
// or repeating beats.
module vm86_sensitive_insn_monitor
   import vsim_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // in_vm86, code_window, cs_in, ip_in, sp_in, flags_in, stack_word0,
   // stack_word1, stack_word2, table_index, table_value, zero pad
   input  logic [255:0] req_tdata,
   // operation
   input  logic         req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cs_out, ip_out, sp_out, flags_out, vif_out, store_count, store_wide,
   // store0, store1, store2, zero pad
   output logic [183:0] rsp_tdata,
   // outcome
   output logic [1:0]   rsp_tuser
);

   req_item_type req_item;
   decode_type   req_dec;
   logic         req_accept;
   logic         advance;

   logic         s1_valid_ff,  s1_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         vif_ff,       vif_in;
   logic         s1_op_ff;
   req_item_type s1_item_ff;
   decode_type   s1_dec_ff;
   logic [31:0]  vec_rd_ff;
   logic [31:0]  vec_mem [256];

   rsp_item_type rsp_item_ff, rsp_item_in;
   outcome_type  outcome_ff,  outcome_in;

   // handshake and stage control
   assign req_item   = req_item_type'(req_tdata);
   assign req_dec    = scan_code(req_item.code_window);
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vif_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && s1_valid_ff) begin
            vif_ff <= vif_in;
         end
      end
   end

   // vector table, written and read at acceptance
   always_ff @(posedge clock) begin
      if (req_accept && (req_tuser == OP_TABLE_WRITE)) begin
         vec_mem[req_item.table_index] <= req_item.table_value;
      end
      if (req_accept) begin
         vec_rd_ff <= vec_mem[req_dec.vec];
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= req_tuser;
         s1_item_ff <= req_item;
         s1_dec_ff  <= req_dec;
      end
   end

   // emulation of the decoded instruction
   always_comb begin
      logic [15:0] ip_adv;
      ip_adv      = s1_item_ff.ip_in + {13'd0, s1_dec_ff.pos};
      rsp_item_in = '0;
      rsp_item_in.cs_out    = s1_item_ff.cs_in;
      rsp_item_in.ip_out    = s1_item_ff.ip_in;
      rsp_item_in.sp_out    = s1_item_ff.sp_in;
      rsp_item_in.flags_out = s1_item_ff.flags_in;
      outcome_in  = OUT_UNHANDLED;
      vif_in      = vif_ff;

      if (s1_op_ff == OP_TABLE_WRITE) begin
         outcome_in = OUT_EMULATED;
      end else if (s1_item_ff.in_vm86) begin
         rsp_item_in.ip_out = ip_adv;
         if (s1_dec_ff.found) begin
            case (s1_dec_ff.opcode)
               OPC_INT: begin
                  if (s1_dec_ff.vec_ok) begin
                     if ((s1_dec_ff.vec == VEC_EXIT) || (s1_dec_ff.vec == VEC_BREAK)) begin
                        outcome_in = OUT_TERMINATE;
                     end else if (s1_dec_ff.vec == VEC_SLEEP) begin
                        outcome_in         = OUT_SLEEP;
                        rsp_item_in.ip_out = ip_adv + 16'd2;
                     end else begin
                        outcome_in              = OUT_EMULATED;
                        rsp_item_in.sp_out      = s1_item_ff.sp_in - 16'd6;
                        rsp_item_in.store_count = 2'd3;
                        rsp_item_in.store0      = {16'd0, ip_adv + 16'd2};
                        rsp_item_in.store1      = {16'd0, s1_item_ff.cs_in};
                        rsp_item_in.store2      =
                           with_vif(s1_item_ff.flags_in & WORD_MASK, vif_ff);
                        rsp_item_in.cs_out      = vec_rd_ff[31:16];
                        rsp_item_in.ip_out      = vec_rd_ff[15:0];
                     end
                  end
               end
               OPC_PUSHF: begin
                  outcome_in              = OUT_EMULATED;
                  rsp_item_in.store_count = 2'd1;
                  rsp_item_in.ip_out      = ip_adv + 16'd1;
                  if (s1_dec_ff.data32) begin
                     rsp_item_in.sp_out     = s1_item_ff.sp_in - 16'd4;
                     rsp_item_in.store_wide = 1'b1;
                     rsp_item_in.store0     =
                        with_vif(s1_item_ff.flags_in & FLAGS_KEPT, vif_ff);
                  end else begin
                     rsp_item_in.sp_out = s1_item_ff.sp_in - 16'd2;
                     rsp_item_in.store0 =
                        with_vif(s1_item_ff.flags_in & WORD_MASK, vif_ff);
                  end
               end
               OPC_POPF: begin
                  outcome_in         = OUT_EMULATED;
                  rsp_item_in.ip_out = ip_adv + 16'd1;
                  vif_in             = s1_item_ff.stack_word0[9];
                  if (s1_dec_ff.data32) begin
                     rsp_item_in.flags_out =
                        (s1_item_ff.stack_word0 & FLAGS_KEPT) | FLAG_VM | FLAG_IF;
                     rsp_item_in.sp_out    = s1_item_ff.sp_in + 16'd4;
                  end else begin
                     rsp_item_in.flags_out =
                        (s1_item_ff.stack_word0 & WORD_MASK) | FLAG_VM | FLAG_IF;
                     rsp_item_in.sp_out    = s1_item_ff.sp_in + 16'd2;
                  end
               end
               OPC_IRET: begin
                  outcome_in         = OUT_EMULATED;
                  rsp_item_in.ip_out = s1_item_ff.stack_word0[15:0];
                  rsp_item_in.cs_out = s1_item_ff.stack_word1[15:0];
                  vif_in             = s1_item_ff.stack_word2[9];
                  if (s1_dec_ff.data32) begin
                     rsp_item_in.flags_out = s1_item_ff.stack_word2 | FLAG_VM | FLAG_IF;
                     rsp_item_in.sp_out    = s1_item_ff.sp_in + 16'd12;
                  end else begin
                     rsp_item_in.flags_out =
                        (s1_item_ff.stack_word2 & WORD_MASK) | FLAG_VM | FLAG_IF;
                     rsp_item_in.sp_out    = s1_item_ff.sp_in + 16'd6;
                  end
               end
               OPC_CLI: begin
                  outcome_in         = OUT_EMULATED;
                  vif_in             = 1'b0;
                  rsp_item_in.ip_out = ip_adv + 16'd1;
               end
               OPC_STI: begin
                  outcome_in         = OUT_EMULATED;
                  vif_in             = 1'b1;
                  rsp_item_in.ip_out = ip_adv + 16'd1;
               end
               default: begin
                  outcome_in = OUT_UNHANDLED;
               end
            endcase
         end
      end
      rsp_item_in.vif_out = vif_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_item_ff <= rsp_item_in;
         outcome_ff  <= outcome_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tuser  = outcome_ff;

endmodule

FILE: rtl/vsim_checker.sv
// ----------------------------------------------------------------------------
// vsim_checker
// port-level checks on the vm86 sensitive instruction monitor
// ----------------------------------------------------------------------------
`include "vm86_sensitive_insn_monitor_macros.svh"

module vsim_checker
   import vsim_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [183:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   rsp_item_type rsp_view;
   logic         rsp_stall;
   logic         no_store;
   logic         partial_store;
   logic         upper_clear;
   logic         lower_clear;

   assign rsp_view      = rsp_item_type'(rsp_tdata);
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign no_store      = (rsp_view.store_count == 2'd0);
   assign partial_store = rsp_tvalid && (rsp_view.store_count != 2'd3);
   assign upper_clear   = (rsp_view.store1 == 32'd0) && (rsp_view.store2 == 32'd0);
   assign lower_clear   = (rsp_view.store0 == 32'd0) && !rsp_view.store_wide;

   // a stalled response beat holds
   `VSIM_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // no response straight after reset
   `VSIM_ASSERT_RESET(a_rsp_reset, !rsp_tvalid)

   // only emulated beats carry stack stores
   `VSIM_ASSERT_IMPL(a_store_outcome, rsp_tvalid && (rsp_tuser != OUT_EMULATED), no_store)

   // store fields beyond the count are clear, narrow when nothing stored
   `VSIM_ASSERT_IMPL(a_store_clear, partial_store, upper_clear && (!no_store || lower_clear))

endmodule

bind vm86_sensitive_insn_monitor vsim_checker u_vsim_checker (.*);

FILE: dv/vm86_monitor_checker.sv
// ----------------------------------------------------------------------------
// vm86 monitor checker
// watches both streams of the vm86 sensitive instruction monitor, keeps its
// own image of the virtual interrupt flag and the vector table, predicts each
// response beat and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module vm86_monitor_checker
   import vsim_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // in_vm86, code_window, cs_in, ip_in, sp_in, flags_in, stack_word0,
   // stack_word1, stack_word2, table_index, table_value, zero pad
   input  logic [255:0] req_tdata,
   // operation
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cs_out, ip_out, sp_out, flags_out, vif_out, store_count, store_wide,
   // store0, store1, store2, zero pad
   input  logic [183:0] rsp_tdata,
   // outcome
   input  logic [1:0]   rsp_tuser,
   output int unsigned  mismatches,
   output int unsigned  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCAN_BYTES = (PREFIX_WINDOW < 4) ? PREFIX_WINDOW : 4;

   typedef struct packed {
      outcome_type  outcome;
      rsp_item_type body;
   } trap_result_type;

   logic            guest_vif;
   logic [31:0]     vector_image [256];
   trap_result_type expected_results [$];
   int unsigned     mismatch_count = 0;
   int unsigned     beat_count = 0;

   // flags image carrying the virtual interrupt flag in place of IF
   function automatic logic [31:0] vif_image(input logic [31:0] v);
      return guest_vif ? (v | FLAG_IF) : (v & ~FLAG_IF);
   endfunction

   // work out the response to one request beat, updating the state images
   function automatic trap_result_type predict_trap(input logic op, input req_item_type r);
      trap_result_type res;
      logic [15:0]  cs, ip, sp;
      logic [31:0]  fl, entry;
      logic [7:0]   b, opc, vec;
      int           pos;
      bit           found, data32;
      res    = '0;
      res.outcome = OUT_UNHANDLED;
      cs     = r.cs_in;
      ip     = r.ip_in;
      sp     = r.sp_in;
      fl     = r.flags_in;
      pos    = 0;
      found  = 1'b0;
      data32 = 1'b0;
      opc    = '0;
      if (op == OP_TABLE_WRITE) begin
         vector_image[r.table_index] = r.table_value;
         res.outcome = OUT_EMULATED;
      end else if (r.in_vm86) begin
         // skip size prefixes, one IP step each
         for (int i = 0; i < SCAN_BYTES; i++) begin
            if (!found) begin
               b = r.code_window[8*i +: 8];
               if (b == PFX_DATA32 || b == PFX_ADDR32) begin
                  if (b == PFX_DATA32) data32 = 1'b1;
                  pos++;
                  ip = ip + 16'd1;
               end else begin
                  opc   = b;
                  found = 1'b1;
               end
            end
         end
         if (found) begin
            case (opc)
               OPC_INT: begin
                  // vector byte must lie inside the window
                  if (pos + 1 < 4) begin
                     vec = r.code_window[8*(pos+1) +: 8];
                     if (vec == VEC_EXIT || vec == VEC_BREAK) begin
                        res.outcome = OUT_TERMINATE;
                     end else if (vec == VEC_SLEEP) begin
                        res.outcome = OUT_SLEEP;
                        ip = ip + 16'd2;
                     end else begin
                        entry = vector_image[vec];
                        res.outcome = OUT_EMULATED;
                        sp = sp - 16'd6;
                        res.body.store_count = 2'd3;
                        res.body.store0 = {16'h0, ip + 16'd2};
                        res.body.store1 = {16'h0, cs};
                        res.body.store2 = vif_image(fl & WORD_MASK);
                        cs = entry[31:16];
                        ip = entry[15:0];
                     end
                  end
               end
               OPC_PUSHF: begin
                  res.outcome = OUT_EMULATED;
                  res.body.store_count = 2'd1;
                  if (data32) begin
                     sp = sp - 16'd4;
                     res.body.store_wide = 1'b1;
                     res.body.store0 = vif_image(fl & FLAGS_KEPT);
                  end else begin
                     sp = sp - 16'd2;
                     res.body.store0 = vif_image(fl & WORD_MASK);
                  end
                  ip = ip + 16'd1;
               end
               OPC_POPF: begin
                  res.outcome = OUT_EMULATED;
                  if (data32) begin
                     fl = (r.stack_word0 & FLAGS_KEPT) | FLAG_VM | FLAG_IF;
                     sp = sp + 16'd4;
                  end else begin
                     fl = (r.stack_word0 & WORD_MASK) | FLAG_VM | FLAG_IF;
                     sp = sp + 16'd2;
                  end
                  guest_vif = (r.stack_word0 & FLAG_IF) != 0;
                  ip = ip + 16'd1;
               end
               OPC_IRET: begin
                  res.outcome = OUT_EMULATED;
                  ip = r.stack_word0[15:0];
                  cs = r.stack_word1[15:0];
                  if (data32) begin
                     fl = r.stack_word2 | FLAG_VM | FLAG_IF;
                     sp = sp + 16'd12;
                  end else begin
                     fl = (r.stack_word2 & WORD_MASK) | FLAG_VM | FLAG_IF;
                     sp = sp + 16'd6;
                  end
                  guest_vif = (r.stack_word2 & FLAG_IF) != 0;
               end
               OPC_CLI: begin
                  res.outcome = OUT_EMULATED;
                  guest_vif = 1'b0;
                  ip = ip + 16'd1;
               end
               OPC_STI: begin
                  res.outcome = OUT_EMULATED;
                  guest_vif = 1'b1;
                  ip = ip + 16'd1;
               end
               default: begin
                  // unknown opcode, only the prefixes are skipped
               end
            endcase
         end
      end
      res.body.cs_out    = cs;
      res.body.ip_out    = ip;
      res.body.sp_out    = sp;
      res.body.flags_out = fl;
      res.body.vif_out   = guest_vif;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] seen);
      if (seen !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("beat %0d: %s mismatch, expected %h got %h",
                     beat_count, name, want, seen);
      end
   endfunction

   // track accepted beats on both channels
   always @(posedge clock) begin
      trap_result_type want;
      rsp_item_type    got;
      if (reset) begin
         guest_vif = 1'b0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_trap(req_tuser, req_item_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("beat %0d: response with nothing expected, data %h",
                           beat_count, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("outcome", 32'(want.outcome), 32'(rsp_tuser));
               check_field("cs_out", 32'(want.body.cs_out), 32'(got.cs_out));
               check_field("ip_out", 32'(want.body.ip_out), 32'(got.ip_out));
               check_field("sp_out", 32'(want.body.sp_out), 32'(got.sp_out));
               check_field("flags_out", want.body.flags_out, got.flags_out);
               check_field("vif_out", 32'(want.body.vif_out), 32'(got.vif_out));
               check_field("store_count", 32'(want.body.store_count),
                           32'(got.store_count));
               check_field("store_wide", 32'(want.body.store_wide), 32'(got.store_wide));
               check_field("store0", want.body.store0, got.store0);
               check_field("store1", want.body.store1, got.store1);
               check_field("store2", want.body.store2, got.store2);
               check_field("pad", 32'(want.body.pad), 32'(got.pad));
            end
            beat_count++;
         end
      end
      mismatches  = mismatch_count;
      outstanding = expected_results.size();
   end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the vm86 sensitive instruction monitor: a directed
// pass over every opcode, prefix form and special vector, then random trap and
// table-write beats under random idling on both streams
// ----------------------------------------------------------------------------
module tb_top
   import vsim_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RANDOM_ITEMS = 1800;
   localparam int unsigned CYCLE_LIMIT  = 400_000;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic [255:0] req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         rsp_tready = 1'b0;
   wire          req_tready;
   wire          rsp_tvalid;
   wire  [183:0] rsp_tdata;
   wire  [1:0]   rsp_tuser;
   int unsigned  mismatches;
   int unsigned  outstanding;
   int unsigned  cycles = 0;
   bit           throttle = 1'b1;
   bit           vector_loaded [256];

   vm86_sensitive_insn_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   vm86_monitor_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response back-pressure in random bursts
   initial begin
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (throttle && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // vector an emulate beat would fetch from the table, if any
   function automatic bit vector_needed(input req_item_type item, output logic [7:0] vec);
      int  pos;
      bit  stop;
      logic [7:0] b;
      vec  = '0;
      pos  = 0;
      stop = 1'b0;
      if (!item.in_vm86) return 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!stop) begin
            b = item.code_window[8*i +: 8];
            if (b == PFX_DATA32 || b == PFX_ADDR32) pos++;
            else stop = 1'b1;
         end
      end
      if (pos >= 3 || item.code_window[8*pos +: 8] != OPC_INT) return 1'b0;
      vec = item.code_window[8*(pos+1) +: 8];
      return !(vec == VEC_BREAK || vec == VEC_EXIT || vec == VEC_SLEEP);
   endfunction

   // one request beat, with an optional idle burst in front
   task automatic send_beat(input logic op, input req_item_type item);
      if (throttle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= item;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_TABLE_WRITE) vector_loaded[item.table_index] = 1'b1;
   endtask

   task automatic load_vector(input logic [7:0] idx, input logic [31:0] value);
      req_item_type item;
      item = '0;
      item.table_index = idx;
      item.table_value = value;
      send_beat(OP_TABLE_WRITE, item);
   endtask

   // an INT through an empty entry first gets the entry loaded
   task automatic issue(input logic op, input req_item_type item);
      logic [7:0] vec;
      if (op == OP_EMULATE && vector_needed(item, vec) && !vector_loaded[vec])
         load_vector(vec, $urandom());
      send_beat(op, item);
   endtask

   function automatic req_item_type make_trap(input logic [31:0] window,
                                              input logic [15:0] ip, input logic [15:0] sp,
                                              input logic [31:0] fl, input logic [31:0] s0,
                                              input logic [31:0] s2);
      req_item_type item;
      item             = '0;
      item.in_vm86     = 1'b1;
      item.code_window = window;
      item.cs_in       = 16'($urandom());
      item.ip_in       = ip;
      item.sp_in       = sp;
      item.flags_in    = fl;
      item.stack_word0 = s0;
      item.stack_word1 = $urandom();
      item.stack_word2 = s2;
      item.table_index = 8'($urandom());
      item.table_value = $urandom();
      return item;
   endfunction

   // mostly well-formed instructions behind a few prefixes, some noise
   function automatic void random_item(output logic op, output req_item_type item);
      int kind, npfx;
      logic [7:0] opc;
      item             = '0;
      item.in_vm86     = 1'b1;
      item.code_window = $urandom();
      item.cs_in       = 16'($urandom());
      item.ip_in       = 16'($urandom());
      item.sp_in       = 16'($urandom());
      item.flags_in    = $urandom();
      item.stack_word0 = $urandom();
      item.stack_word1 = $urandom();
      item.stack_word2 = $urandom();
      item.table_index = 8'($urandom());
      item.table_value = $urandom();
      case ($urandom_range(0, 9))
         0: item.sp_in = 16'h0000;
         1: item.sp_in = 16'hFFFF;
         2: item.ip_in = 16'hFFFF;
         default: ;
      endcase
      kind = $urandom_range(0, 99);
      op   = OP_EMULATE;
      if (kind < 8) begin
         op = OP_TABLE_WRITE;
         return;
      end
      if (kind < 13) begin
         item.in_vm86 = 1'b0;
         return;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: npfx = 0;
         5, 6, 7:       npfx = 1;
         8:             npfx = 2;
         default:       npfx = $urandom_range(3, 4);
      endcase
      for (int k = 0; k < npfx; k++)
         item.code_window[8*k +: 8] = $urandom_range(0, 1) ? PFX_DATA32 : PFX_ADDR32;
      if (npfx < 4) begin
         case ($urandom_range(0, 7))
            0, 1:    opc = OPC_INT;
            2:       opc = OPC_PUSHF;
            3:       opc = OPC_POPF;
            4:       opc = OPC_IRET;
            5:       opc = OPC_CLI;
            6:       opc = OPC_STI;
            default: opc = 8'($urandom());
         endcase
         item.code_window[8*npfx +: 8] = opc;
         if (opc == OPC_INT && npfx < 3 && $urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0:       item.code_window[8*(npfx+1) +: 8] = VEC_BREAK;
               1:       item.code_window[8*(npfx+1) +: 8] = VEC_EXIT;
               default: item.code_window[8*(npfx+1) +: 8] = VEC_SLEEP;
            endcase
         end
      end
   endfunction

   // stimulus and verdict
   initial begin
      logic         op;
      req_item_type item;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // table extremes, then each opcode and special path
      load_vector(8'h00, 32'h0000_0000);
      load_vector(8'hFF, 32'hFFFF_FFFF);
      load_vector(8'h21, 32'hF000_1234);
      issue(OP_EMULATE, make_trap(32'h9090_21CD, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_00CD, 16'h0000, 16'hFFFF, 32'h0000_0000, 0, 0));
      issue(OP_EMULATE, make_trap(32'h00FF_CD67, 16'h1000, 16'h0004, 32'h0000_0200, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_03CD, 16'h2000, 16'h0100, 32'h0, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_FBCD, 16'h2000, 16'h0100, 32'h0, 0, 0));
      // sleep with IP wrapping
      issue(OP_EMULATE, make_trap(32'h00FC_CD66, 16'hFFFE, 16'h0100, 32'h0, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_00FB, 16'h0010, 16'h0100, 32'h0, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_009C, 16'h0010, 16'h0000, 32'hFFFF_FFFF, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_9C66, 16'h0010, 16'h0002, 32'hFFFF_FFFF, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_00FA, 16'hFFFF, 16'h0100, 32'h0, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_009C, 16'h0010, 16'h0100, 32'hFFFF_FFFF, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_009D, 16'h0010, 16'hFFFE, 32'h0, 32'hFFFF_FFFF, 0));
      issue(OP_EMULATE, make_trap(32'h0000_9D66, 16'h0010, 16'hFFFC, 32'hFFFF_FFFF, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_00CF, 16'h0010, 16'hFFFA, 32'h0, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF));
      issue(OP_EMULATE, make_trap(32'h0000_CF66, 16'h0010, 16'hFFF4, 32'h0, 32'h0001_0002,
                                  32'hFFFF_FDFF));
      // address prefix alone keeps word forms
      issue(OP_EMULATE, make_trap(32'h0000_9C67, 16'h0010, 16'h0100, 32'h0000_0DFF, 0, 0));
      // prefixes fill the window, then INT with its vector byte cut off
      issue(OP_EMULATE, make_trap(32'h6766_6766, 16'hFFFE, 16'h0100, 32'h0, 0, 0));
      issue(OP_EMULATE, make_trap(32'hCD66_6666, 16'h0010, 16'h0100, 32'h0, 0, 0));
      issue(OP_EMULATE, make_trap(32'h0000_0090, 16'h0010, 16'h0100, 32'h0, 0, 0));
      item = make_trap(32'h0000_21CD, 16'h0010, 16'h0100, 32'hFFFF_FFFF, 0, 0);
      item.in_vm86 = 1'b0;
      issue(OP_EMULATE, item);

      // random part: alternate throttled and full-rate stretches, calm tail
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         throttle = (n < RANDOM_ITEMS - 300) && ((n / 200) % 4 != 3);
         random_item(op, item);
         issue(op, item);
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: vm86_sensitive_insn_monitor.f
+incdir+rtl
rtl/vsim_pkg.sv
rtl/vm86_sensitive_insn_monitor.sv
rtl/vsim_checker.sv
dv/vm86_monitor_checker.sv
dv/tb_top.sv
